// ----- hdl/websocket_frame_deframer_defines.svh -----
// Assertion macros shared by the deframer checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define WSFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define WSFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define WSFD_ASSERT_NXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/wsfd_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
package wsfd_pkg;

  localparam int PAYLOAD_LEN_BITS = 31;
  localparam int LEN_W            = PAYLOAD_LEN_BITS;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_RESERVED     = 3'd1;
  localparam logic [2:0] ERR_LEN_RANGE    = 3'd2;
  localparam logic [2:0] ERR_ZERO_LEN     = 3'd3;
  localparam logic [2:0] ERR_OPCODE       = 3'd4;
  localparam logic [2:0] ERR_FRAG_ORDER   = 3'd5;
  localparam logic [2:0] ERR_CTRL_PAYLOAD = 3'd6;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] KEY_LAST   = 3'd3;

  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_LEN16   = 6'b000100,
    PH_LEN64   = 6'b001000,
    PH_KEY     = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } wsfd_phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       is_text;
    logic       frame_last;
    logic       msg_final;
    logic [2:0] err;
  } wsfd_result_t;

endpackage

// ----- hdl/wsfd_in_stage.sv -----
// Input register: holds one received byte until the parser takes it.
module wsfd_in_stage import wsfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       byte_vld,
  output logic [7:0] byte_val
);

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;

  assign in_ready = !vld_r || take;
  assign vld_nxt  = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  assign byte_vld = vld_r;
  assign byte_val = byte_r;

endmodule

// ----- hdl/wsfd_parser.sv -----
// Frame header parser, header checks and payload unmasking.
module wsfd_parser import wsfd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   rx_byte,
  output logic         res_vld,
  output wsfd_result_t res
);

  wsfd_phase_t      phase_r, phase_nxt;
  logic [2:0]       ext_r, ext_nxt;
  logic             fin_r, fin_nxt;
  logic [2:0]       rsv_r, rsv_nxt;
  logic [3:0]       op_r, op_nxt;
  logic             mask_r, mask_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;   // length went above the limit
  logic [31:0]      key_r, key_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [1:0]       midx_r, midx_nxt;
  logic             msg_r, msg_nxt;
  logic             text_r, text_nxt;
  logic             halted_r, halted_nxt;

  logic [LEN_W-1:0] len_cand;
  logic             ovf_cand;
  logic             do_finish;
  logic             data_op;
  logic             last;
  logic [7:0]       key_byte;

  always_comb begin
    phase_nxt  = phase_r;
    ext_nxt    = ext_r;
    fin_nxt    = fin_r;
    rsv_nxt    = rsv_r;
    op_nxt     = op_r;
    mask_nxt   = mask_r;
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    key_nxt    = key_r;
    rem_nxt    = rem_r;
    midx_nxt   = midx_r;
    msg_nxt    = msg_r;
    text_nxt   = text_r;
    halted_nxt = halted_r;
    res_vld    = 1'b0;
    res        = '0;
    len_cand   = len_r;
    ovf_cand   = ovf_r;
    do_finish  = 1'b0;
    data_op    = (op_r == OP_TEXT) || (op_r == OP_BIN);
    last       = (rem_r <= LEN_W'(1));
    key_byte   = key_r[31:24];
    case (midx_r)
      2'd0: key_byte = key_r[31:24];
      2'd1: key_byte = key_r[23:16];
      2'd2: key_byte = key_r[15:8];
      2'd3: key_byte = key_r[7:0];
      default: key_byte = key_r[31:24];
    endcase

    if (!halted_r) begin
      case (phase_r)
        PH_HDR1: begin
          mask_nxt = rx_byte[7];
          ext_nxt  = 3'd0;
          if (rx_byte[6:0] == LEN_CODE_16) begin
            phase_nxt = PH_LEN16;
          end else if (rx_byte[6:0] == LEN_CODE_64) begin
            phase_nxt = PH_LEN64;
          end else begin
            len_cand = LEN_W'(rx_byte[6:0]);
            ovf_cand = 1'b0;
            len_nxt  = len_cand;
            ovf_nxt  = ovf_cand;
            if (rx_byte[7]) begin
              phase_nxt = PH_KEY;
            end else begin
              do_finish = 1'b1;
            end
          end
        end
        PH_LEN16, PH_LEN64: begin
          // bits shifted past the kept width make the length oversize
          len_cand = {len_r[LEN_W-9:0], rx_byte};
          ovf_cand = ovf_r || (|len_r[LEN_W-1 -: 8]);
          len_nxt  = len_cand;
          ovf_nxt  = ovf_cand;
          if ((phase_r == PH_LEN16 && ext_r >= EXT16_LAST) ||
              (phase_r == PH_LEN64 && ext_r >= EXT64_LAST)) begin
            ext_nxt = 3'd0;
            if (mask_r) begin
              phase_nxt = PH_KEY;
            end else begin
              do_finish = 1'b1;
            end
          end else begin
            ext_nxt = ext_r + 3'd1;
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], rx_byte};
          if (ext_r >= KEY_LAST) begin
            ext_nxt   = 3'd0;
            do_finish = 1'b1;
          end else begin
            ext_nxt = ext_r + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          midx_nxt = midx_r + 2'd1;
          rem_nxt  = last ? '0 : rem_r - LEN_W'(1);
          if (op_r == OP_PING || op_r == OP_PONG) begin
            // control payload is dropped; its end is a protocol error
            if (last) begin
              halted_nxt = 1'b1;
              res_vld    = 1'b1;
              res.kind   = KIND_ERROR;
              res.err    = ERR_CTRL_PAYLOAD;
            end
          end else begin
            if (last) begin
              phase_nxt = PH_HDR0;
              if (fin_r) begin
                msg_nxt = 1'b0;
              end
            end
            res_vld        = 1'b1;
            res.kind       = KIND_DATA;
            res.data       = rx_byte ^ key_byte;
            res.is_text    = text_r;
            res.frame_last = last;
            res.msg_final  = last && fin_r;
          end
        end
        default: begin
          fin_nxt   = rx_byte[7];
          rsv_nxt   = rx_byte[6:4];
          op_nxt    = rx_byte[3:0];
          mask_nxt  = 1'b0;
          key_nxt   = '0;
          len_nxt   = '0;
          ovf_nxt   = 1'b0;
          ext_nxt   = 3'd0;
          midx_nxt  = 2'd0;
          phase_nxt = PH_HDR1;
        end
      endcase

      if (do_finish) begin
        if (rsv_r != 3'd0) begin
          halted_nxt = 1'b1;
          res_vld    = 1'b1;
          res.kind   = KIND_ERROR;
          res.err    = ERR_RESERVED;
        end else if (ovf_cand) begin
          halted_nxt = 1'b1;
          res_vld    = 1'b1;
          res.kind   = KIND_ERROR;
          res.err    = ERR_LEN_RANGE;
        end else if (len_cand == '0) begin
          halted_nxt = 1'b1;
          res_vld    = 1'b1;
          res.kind   = KIND_ERROR;
          res.err    = ERR_ZERO_LEN;
        end else if (!(op_r <= OP_BIN || op_r == OP_CLOSE || op_r == OP_PING ||
                       op_r == OP_PONG)) begin
          halted_nxt = 1'b1;
          res_vld    = 1'b1;
          res.kind   = KIND_ERROR;
          res.err    = ERR_OPCODE;
        end else if (op_r == OP_CLOSE) begin
          halted_nxt = 1'b1;
          res_vld    = 1'b1;
          res.kind   = KIND_CLOSE;
          res.err    = ERR_NONE;
        end else if ((data_op && msg_r) || (op_r == OP_CONT && !msg_r)) begin
          halted_nxt = 1'b1;
          res_vld    = 1'b1;
          res.kind   = KIND_ERROR;
          res.err    = ERR_FRAG_ORDER;
        end else begin
          if (data_op) begin
            text_nxt = (op_r == OP_TEXT);
            msg_nxt  = 1'b1;
          end
          rem_nxt   = len_cand;
          midx_nxt  = 2'd0;
          ext_nxt   = 3'd0;
          phase_nxt = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      ext_r    <= '0;
      fin_r    <= 1'b0;
      rsv_r    <= '0;
      op_r     <= '0;
      mask_r   <= 1'b0;
      len_r    <= '0;
      ovf_r    <= 1'b0;
      key_r    <= '0;
      rem_r    <= '0;
      midx_r   <= '0;
      msg_r    <= 1'b0;
      text_r   <= 1'b0;
      halted_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      ext_r    <= ext_nxt;
      fin_r    <= fin_nxt;
      rsv_r    <= rsv_nxt;
      op_r     <= op_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      ovf_r    <= ovf_nxt;
      key_r    <= key_nxt;
      rem_r    <= rem_nxt;
      midx_r   <= midx_nxt;
      msg_r    <= msg_nxt;
      text_r   <= text_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

// ----- hdl/wsfd_out_stage.sv -----
// Result register on the output channel.
module wsfd_out_stage import wsfd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  wsfd_result_t res,
  input  logic         out_ready,
  output logic         out_valid,
  output wsfd_result_t res_q
);

  logic         vld_r, vld_nxt;
  wsfd_result_t res_r;

  assign vld_nxt = load ? 1'b1 : (out_ready ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign res_q     = res_r;

endmodule

// ----- hdl/websocket_frame_deframer.sv -----
// WebSocket receive deframer: parses frame headers, checks them and
// unmasks payload words. One byte is accepted per cycle with no bubbles
// while out_ready keeps up; a byte goes into the input register, then
// through the single parse stage into the result register, which drives
// out_valid. Header bytes and dropped bytes are consumed but give no word.
// Stalls come only from out_ready back-pressure. A close frame or any
// protocol error gives one disconnect word and the block then drops all
// input until reset. Ping and pong payloads produce no data words; the
// end of one is a protocol error. No memory, no clearing pass.
module websocket_frame_deframer import wsfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic       out_message_is_text,
  output logic       out_frame_last,
  output logic       out_message_final,
  output logic [2:0] out_error_code
);

  logic         byte_vld;
  logic [7:0]   byte_val;
  logic         step;
  logic         res_vld;
  wsfd_result_t res;
  wsfd_result_t res_q;

  // parse only when the result register is free or draining this cycle
  assign step = byte_vld && (!out_valid || out_ready);

  wsfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (step),
    .byte_vld   (byte_vld),
    .byte_val   (byte_val)
  );

  wsfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (byte_val),
    .res_vld (res_vld),
    .res     (res)
  );

  wsfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_vld),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_q     (res_q)
  );

  assign out_kind            = res_q.kind;
  assign out_data_byte       = res_q.data;
  assign out_message_is_text = res_q.is_text;
  assign out_frame_last      = res_q.frame_last;
  assign out_message_final   = res_q.msg_final;
  assign out_error_code      = res_q.err;

endmodule

// ----- hdl/wsfd_checker.sv -----
// Port-level checker for the deframer, bound to the top level.
`include "websocket_frame_deframer_defines.svh"

module wsfd_checker import wsfd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_data_byte,
  input logic       out_frame_last,
  input logic       out_message_final,
  input logic [2:0] out_error_code
);

  `WSFD_ASSERT_NXT_ALWAYS(a_rst_clears_out, !rst_n, !out_valid, "out_valid after reset")

  `WSFD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_data_byte) && $stable(out_error_code), "stalled word changed")

  `WSFD_ASSERT_IMP(a_data_word, out_valid && out_kind == KIND_DATA, out_error_code == ERR_NONE && (!out_message_final || out_frame_last), "bad data word marks")

  `WSFD_ASSERT_IMP(a_disc_word, out_valid && out_kind != KIND_DATA, out_data_byte == 8'd0 && !out_frame_last && !out_message_final && ((out_kind == KIND_CLOSE) == (out_error_code == ERR_NONE)), "bad disconnect word")

  `WSFD_ASSERT_NXT(a_halt_after_disc, out_valid && out_ready && out_kind != KIND_DATA, !out_valid, "word after disconnect")

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (.*);

// ----- test/websocket_frame_deframer_tb.sv -----
// Self-checking testbench for the WebSocket frame deframer.
module websocket_frame_deframer_tb;
  import wsfd_pkg::*;

  typedef enum logic [1:0] {LEN_FORM_7, LEN_FORM_16, LEN_FORM_64} len_form_t;

  localparam logic [63:0] LEN_LIMIT = (64'd1 << PAYLOAD_LEN_BITS) - 64'd1;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_data_byte;
  logic       out_message_is_text;
  logic       out_frame_last;
  logic       out_message_final;
  logic [2:0] out_error_code;

  websocket_frame_deframer i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_data_byte       (out_data_byte),
    .out_message_is_text (out_message_is_text),
    .out_frame_last      (out_frame_last),
    .out_message_final   (out_message_final),
    .out_error_code      (out_error_code)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------- decoder
  wsfd_phase_t                 ph;
  logic [2:0]                  ext_cnt;
  logic                        fin_q;
  logic [2:0]                  rsv_q;
  logic [3:0]                  op_q;
  logic                        masked_q;
  logic [63:0]                 len_acc;
  logic [31:0]                 key_q;
  logic [PAYLOAD_LEN_BITS-1:0] remain;
  logic [1:0]                  key_idx;
  logic                        msg_open;
  logic                        msg_text;
  logic                        dead;

  wsfd_result_t expected_words[$];

  task automatic reset_decoder();
    ph = PH_HDR0;
    ext_cnt = '0;
    fin_q = 1'b0;
    rsv_q = '0;
    op_q = OP_CONT;
    masked_q = 1'b0;
    len_acc = '0;
    key_q = '0;
    remain = '0;
    key_idx = '0;
    msg_open = 1'b0;
    msg_text = 1'b0;
    dead = 1'b0;
  endtask

  function automatic wsfd_result_t disconnect_word(input logic [1:0] k, input logic [2:0] e);
    wsfd_result_t w;
    w = '0;
    w.kind = k;
    w.err = e;
    dead = 1'b1;
    return w;
  endfunction

  // Header checks in priority order; returns 1 when a disconnect word results.
  function automatic bit close_header(output wsfd_result_t r);
    logic data_op;
    data_op = (op_q == OP_TEXT) || (op_q == OP_BIN);
    r = '0;
    if (rsv_q != 3'd0)
      r = disconnect_word(KIND_ERROR, ERR_RESERVED);
    else if (len_acc > LEN_LIMIT)
      r = disconnect_word(KIND_ERROR, ERR_LEN_RANGE);
    else if (len_acc == 64'd0)
      r = disconnect_word(KIND_ERROR, ERR_ZERO_LEN);
    else if (!(op_q <= OP_BIN || op_q == OP_CLOSE || op_q == OP_PING || op_q == OP_PONG))
      r = disconnect_word(KIND_ERROR, ERR_OPCODE);
    else if (op_q == OP_CLOSE)
      r = disconnect_word(KIND_CLOSE, ERR_NONE);
    else if ((data_op && msg_open) || (op_q == OP_CONT && !msg_open))
      r = disconnect_word(KIND_ERROR, ERR_FRAG_ORDER);
    else begin
      if (data_op) begin
        msg_text = (op_q == OP_TEXT);
        msg_open = 1'b1;
      end
      remain = len_acc[PAYLOAD_LEN_BITS-1:0];
      key_idx = '0;
      ext_cnt = '0;
      ph = PH_PAYLOAD;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit length_done(output wsfd_result_t r);
    r = '0;
    ext_cnt = '0;
    if (masked_q) begin
      ph = PH_KEY;
      return 1'b0;
    end
    return close_header(r);
  endfunction

  // Advances the decoder by one byte; returns 1 when a word is expected.
  function automatic bit decode_byte(input logic [7:0] b, output wsfd_result_t r);
    logic [7:0] key_b;
    logic       last;
    r = '0;
    if (dead)
      return 1'b0;
    case (ph)
      PH_HDR1: begin
        masked_q = b[7];
        ext_cnt = '0;
        if (b[6:0] == LEN_CODE_16)
          ph = PH_LEN16;
        else if (b[6:0] == LEN_CODE_64)
          ph = PH_LEN64;
        else begin
          len_acc = {57'd0, b[6:0]};
          return length_done(r);
        end
        return 1'b0;
      end
      PH_LEN16, PH_LEN64: begin
        len_acc = {len_acc[55:0], b};
        if (ext_cnt >= ((ph == PH_LEN16) ? EXT16_LAST : EXT64_LAST))
          return length_done(r);
        ext_cnt = ext_cnt + 3'd1;
        return 1'b0;
      end
      PH_KEY: begin
        key_q = {key_q[23:0], b};
        if (ext_cnt >= KEY_LAST) begin
          ext_cnt = '0;
          return close_header(r);
        end
        ext_cnt = ext_cnt + 3'd1;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        key_b = 8'(key_q >> (24 - 8 * key_idx));
        last = (remain <= 1);
        key_idx = key_idx + 2'd1;
        remain = last ? '0 : remain - 1'b1;
        // control frame payload is swallowed; its end is an error
        if (op_q == OP_PING || op_q == OP_PONG) begin
          if (last) begin
            r = disconnect_word(KIND_ERROR, ERR_CTRL_PAYLOAD);
            return 1'b1;
          end
          return 1'b0;
        end
        if (last) begin
          ph = PH_HDR0;
          if (fin_q)
            msg_open = 1'b0;
        end
        r.kind = KIND_DATA;
        r.data = b ^ key_b;
        r.is_text = msg_text;
        r.frame_last = last;
        r.msg_final = last && fin_q;
        r.err = ERR_NONE;
        return 1'b1;
      end
      default: begin
        fin_q = b[7];
        rsv_q = b[6:4];
        op_q = b[3:0];
        masked_q = 1'b0;
        key_q = '0;
        len_acc = '0;
        ext_cnt = '0;
        key_idx = '0;
        ph = PH_HDR1;
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- checker
  int unsigned  mismatches = 0;
  wsfd_result_t got_word;
  wsfd_result_t exp_word;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_word = '{out_kind, out_data_byte, out_message_is_text, out_frame_last,
                   out_message_final, out_error_code};
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: kind %0d data %02h text %0b last %0b final %0b err %0d",
                   got_word.kind, got_word.data, got_word.is_text, got_word.frame_last,
                   got_word.msg_final, got_word.err);
      end else begin
        exp_word = expected_words.pop_front();
        if (got_word.kind !== exp_word.kind || got_word.data !== exp_word.data ||
            got_word.is_text !== exp_word.is_text ||
            got_word.frame_last !== exp_word.frame_last ||
            got_word.msg_final !== exp_word.msg_final || got_word.err !== exp_word.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: exp kind %0d data %02h text %0b last %0b final %0b err %0d / got kind %0d data %02h text %0b last %0b final %0b err %0d",
                     exp_word.kind, exp_word.data, exp_word.is_text, exp_word.frame_last,
                     exp_word.msg_final, exp_word.err, got_word.kind, got_word.data,
                     got_word.is_text, got_word.frame_last, got_word.msg_final, got_word.err);
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  logic [8:0] ready_tick = '0;

  always @(negedge clk) begin
    ready_tick <= ready_tick + 9'd1;
    case (ready_tick[8:7])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
      2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (ready_tick[2:0] != 3'd5);
    endcase
  end

  // ---------------------------------------------------------------- sender
  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b);
    wsfd_result_t r;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(0, 12);
    end else
      burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (decode_byte(b, r))
      expected_words.push_back(r);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic drain_words(input int unsigned settle);
    in_valid <= 1'b0;
    while (expected_words.size() != 0)
      @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] first, input bit masked, input len_form_t form,
                            input logic [63:0] len, input logic [31:0] key,
                            input int unsigned n_payload, input bit fill_extremes);
    logic [6:0] code;
    int         i;
    code = (form == LEN_FORM_16) ? LEN_CODE_16 :
           (form == LEN_FORM_64) ? LEN_CODE_64 : len[6:0];
    send_byte(first);
    send_byte({masked, code});
    if (form == LEN_FORM_16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (form == LEN_FORM_64) begin
      for (i = 7; i >= 0; i--)
        send_byte(len[8*i +: 8]);
    end
    if (masked)
      for (i = 3; i >= 0; i--)
        send_byte(key[8*i +: 8]);
    for (i = 0; i < int'(n_payload); i++)
      send_byte(fill_extremes ? ((i % 2 == 0) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_basic_frames();
    send_frame({1'b1, 3'b000, OP_TEXT}, 1'b0, LEN_FORM_7, 64'd1, 32'h0, 1, 1'b1);
    send_frame({1'b0, 3'b000, OP_BIN}, 1'b1, LEN_FORM_7, 64'd2, 32'hFFFF_FFFF, 2, 1'b1);
    // extended lengths that would fit in the short code are taken as is
    send_frame({1'b1, 3'b000, OP_CONT}, 1'b0, LEN_FORM_16, 64'd3, 32'h0, 3, 1'b0);
    send_frame({1'b1, 3'b000, OP_TEXT}, 1'b0, LEN_FORM_64, 64'd1, 32'h0, 1, 1'b0);
    drain_words(4);
  endtask

  task automatic test_fragmented_messages();
    int unsigned stop_at;
    int unsigned next_pause;
    int unsigned pick;
    int unsigned len;
    logic [3:0]  op;
    bit          fin;
    len_form_t   form;
    stop_at = bytes_sent + 2000;
    next_pause = bytes_sent + 600;
    while (bytes_sent < stop_at) begin
      op = msg_open ? OP_CONT : (($urandom_range(0, 1) == 1) ? OP_TEXT : OP_BIN);
      fin = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        form = LEN_FORM_7;
        len = $urandom_range(1, 12);
      end else if (pick < 16) begin
        form = LEN_FORM_7;
        len = $urandom_range(120, 125);
      end else if (pick < 18) begin
        form = LEN_FORM_16;
        len = $urandom_range(1, 300);
      end else begin
        form = LEN_FORM_64;
        len = $urandom_range(1, 140);
      end
      send_frame({fin, 3'b000, op}, ($urandom_range(0, 9) < 7), form, 64'(len),
                 $urandom, len, 1'b0);
      if (bytes_sent >= next_pause) begin
        drain_words(4);
        next_pause = bytes_sent + 600;
      end
    end
  endtask

  // Only one disconnect per reset, so each run picks one kind at random.
  task automatic test_disconnect();
    int unsigned which;
    logic [63:0] len;
    logic [3:0]  op;
    logic [2:0]  rsv;
    len_form_t   form;
    which = $urandom_range(0, 6);
    form = len_form_t'($urandom_range(0, 2));
    op = msg_open ? OP_CONT : OP_TEXT;
    rsv = 3'd0;
    len = 64'($urandom_range(1, 8));
    case (which)
      0: begin
        rsv = 3'($urandom_range(1, 7));
        op = 4'($urandom_range(0, 15));
        len = 64'($urandom_range(0, 8));
      end
      1: begin
        form = LEN_FORM_64;
        len = ($urandom_range(0, 1) == 1) ? {1'b1, 63'($urandom)}
                                          : (64'd1 << PAYLOAD_LEN_BITS) + 64'($urandom_range(0, 3));
      end
      2: len = 64'd0;
      3: op = ($urandom_range(0, 1) == 1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
      4: op = OP_CLOSE;
      5: op = msg_open ? (($urandom_range(0, 1) == 1) ? OP_TEXT : OP_BIN) : OP_CONT;
      default: op = ($urandom_range(0, 1) == 1) ? OP_PING : OP_PONG;
    endcase
    send_frame({1'($urandom_range(0, 1)), rsv, op}, 1'($urandom_range(0, 1)), form, len,
               $urandom, (len[63:4] == 60'd0) ? int'(len) : 4, 1'b0);
  endtask

  task automatic test_halted_input();
    repeat (12) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    reset_decoder();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_basic_frames();
    test_fragmented_messages();
    test_disconnect();
    test_halted_input();
    drain_words(20);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- websocket_frame_deframer.f -----
+incdir+hdl
hdl/wsfd_pkg.sv
hdl/wsfd_in_stage.sv
hdl/wsfd_parser.sv
hdl/wsfd_out_stage.sv
hdl/websocket_frame_deframer.sv
hdl/wsfd_checker.sv
test/websocket_frame_deframer_tb.sv
